// File: design/max_remaining_quantum_scheduler_unit_assert.svh
// Assertion macros shared by the checker of the scheduler unit.
`ifndef MAX_REMAINING_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH
`define MAX_REMAINING_QUANTUM_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MRQS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define MRQS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/mrqs_pkg.sv
package mrqs_pkg;

  // Function codes of an input transfer.
  localparam logic FUNC_ADMIT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_TASK = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // Operation applied to one queue cell in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_t;

endpackage

// File: design/mrqs_cell.sv
module mrqs_cell
  import mrqs_pkg::*;
#(
  parameter int EW = 24
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [EW-1:0] nbr,
  input  logic [EW-1:0] din,
  output logic [EW-1:0] q
);

  // One queue entry; takes its neighbor's entry on a shift, new data on a load.
  always_ff @(posedge clk) begin
    case (op)
      CELL_SHIFT: q <= nbr;
      CELL_LOAD:  q <= din;
      default:    q <= q;
    endcase
  end

endmodule

// File: design/max_remaining_quantum_scheduler_unit.sv
// Longest-remaining-quantum-first scheduler.
// A command is presented on func, task_id and quantum_budget with start high;
// it is taken at a rising edge where start is high and busy is low. Each
// command yields exactly one result, shown for one cycle with done high on
// running_valid, running_id, quanta_left, quanta_elapsed, switched,
// ready_count and status. The receiver cannot stall, so it must take the
// result in that cycle.
// An admit, or a tick with nothing queued, returns its result in the cycle
// after the transfer. For a tick with tasks queued, the ready queue is a
// ring of cells that rotates once through the head cell to find the task
// with the most quanta left (first in order wins a tie), then the commit
// state closes the gap and appends the old running task.
// That rotation sets the tick latency; busy stays high until done.
// Synchronous reset empties the queue and clears the running task; queue
// cells themselves are not reset, since only entries below the fill count
// are ever used.
module max_remaining_quantum_scheduler_unit
  import mrqs_pkg::*;
#(
  parameter int MAX_WAITING  = 16,
  parameter int QUANTUM_BITS = 8,
  parameter int ID_BITS      = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [ID_BITS-1:0]             task_id,
  input  logic [QUANTUM_BITS-1:0]        quantum_budget,
  output logic                           done,
  output logic                           running_valid,
  output logic [ID_BITS-1:0]             running_id,
  output logic [QUANTUM_BITS-1:0]        quanta_left,
  output logic [QUANTUM_BITS-1:0]        quanta_elapsed,
  output logic                           switched,
  output logic [$clog2(MAX_WAITING+1)-1:0] ready_count,
  output logic [1:0]                     status
);

  localparam int IW = $clog2(MAX_WAITING);
  localparam int CW = $clog2(MAX_WAITING + 1);
  localparam int QB = QUANTUM_BITS;
  localparam int EW = ID_BITS + 2 * QB;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t          state;
  logic            active_valid;
  logic [ID_BITS-1:0] active_id;
  logic [QB-1:0]   active_left;
  logic [QB-1:0]   active_total;
  logic [CW-1:0]   count;
  logic [IW-1:0]   scan_idx;
  logic [IW-1:0]   best_idx;
  logic [ID_BITS-1:0] best_id;
  logic [QB-1:0]   best_left;
  logic [QB-1:0]   best_total;
  logic            switched_r;
  status_t         status_r;

  logic [EW-1:0]   cell_q [MAX_WAITING];
  cell_op_t        cell_op [MAX_WAITING];
  logic [EW-1:0]   load_data;

  logic [ID_BITS-1:0] head_id;
  logic [QB-1:0]   head_left;
  logic [QB-1:0]   head_total;
  logic            admit_load;
  logic            scan_take;
  logic [QB-1:0]   refill_left;

  function automatic logic [QUANTUM_BITS-1:0] sat_dec(input logic [QUANTUM_BITS-1:0] v);
    sat_dec = (v == '0) ? '0 : v - 1'b1;
  endfunction

  assign head_id    = cell_q[0][EW-1 -: ID_BITS];
  assign head_left  = cell_q[0][2*QB-1 -: QB];
  assign head_total = cell_q[0][QB-1:0];

  // A running task with nothing left is refilled before the tick goes on.
  assign refill_left = (active_left == '0) ? active_total : active_left;

  assign admit_load = (state == S_IDLE) && start && (func == FUNC_ADMIT) &&
                      active_valid && (count != CW'(MAX_WAITING));

  // During the scan the head cell holds the entry at position scan_idx.
  assign scan_take = (CW'(scan_idx) < count) &&
                     ((scan_idx == '0) || (head_left > best_left));

  // New admits load the input task; the commit loads the old running task.
  assign load_data = (state == S_COMMIT) ? {active_id, active_left, active_total}
                                         : {task_id, quantum_budget, quantum_budget};

  // The ready queue: each cell's neighbor is the next cell, the last wraps to
  // the first so that a full rotation restores the order.
  for (genvar i = 0; i < MAX_WAITING; i++) begin : g_cell
    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (state == S_SCAN) begin
        cell_op[i] = CELL_SHIFT;
      end else if (state == S_COMMIT) begin
        if (CW'(i + 1) == count) begin
          cell_op[i] = CELL_LOAD;
        end else if ((best_idx <= IW'(i)) && (CW'(i + 1) < count)) begin
          cell_op[i] = CELL_SHIFT;
        end
      end else if (admit_load && (CW'(i) == count)) begin
        cell_op[i] = CELL_LOAD;
      end
    end

    mrqs_cell #(
      .EW(EW)
    ) u_cell (
      .clk (clk),
      .op  (cell_op[i]),
      .nbr (cell_q[(i + 1) % MAX_WAITING]),
      .din (load_data),
      .q   (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_valid <= 1'b0;
      active_id    <= '0;
      active_left  <= '0;
      active_total <= '0;
      count        <= '0;
      scan_idx     <= '0;
      best_idx     <= '0;
      done         <= 1'b0;
      switched_r   <= 1'b0;
      status_r     <= STATUS_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            switched_r <= 1'b0;
            status_r   <= STATUS_OK;
            if (func == FUNC_ADMIT) begin
              done <= 1'b1;
              if (!active_valid) begin
                active_valid <= 1'b1;
                active_id    <= task_id;
                active_left  <= quantum_budget;
                active_total <= quantum_budget;
              end else if (count == CW'(MAX_WAITING)) begin
                status_r <= STATUS_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end else if (!active_valid) begin
              done     <= 1'b1;
              status_r <= STATUS_NO_TASK;
            end else if (count == '0) begin
              done        <= 1'b1;
              active_left <= sat_dec(refill_left);
            end else begin
              active_left <= refill_left;
              scan_idx    <= '0;
              state       <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_take) begin
            best_idx   <= scan_idx;
            best_id    <= head_id;
            best_left  <= head_left;
            best_total <= head_total;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == IW'(MAX_WAITING - 1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          active_id    <= best_id;
          active_left  <= sat_dec(best_left);
          active_total <= best_total;
          switched_r   <= 1'b1;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign running_valid  = active_valid;
  assign running_id     = active_valid ? active_id : '0;
  assign quanta_left    = active_valid ? active_left : '0;
  assign quanta_elapsed = active_valid ? QB'(active_total - active_left) : '0;
  assign switched       = switched_r;
  assign ready_count    = count;
  assign status         = status_r;

endmodule

// File: design/mrqs_checker.sv
`include "max_remaining_quantum_scheduler_unit_assert.svh"

module mrqs_checker
  import mrqs_pkg::*;
#(
  parameter int MAX_WAITING  = 16,
  parameter int QUANTUM_BITS = 8,
  parameter int ID_BITS      = 8
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             func,
  input logic                             done,
  input logic                             running_valid,
  input logic [ID_BITS-1:0]               running_id,
  input logic [QUANTUM_BITS-1:0]          quanta_left,
  input logic [QUANTUM_BITS-1:0]          quanta_elapsed,
  input logic                             switched,
  input logic [$clog2(MAX_WAITING+1)-1:0] ready_count,
  input logic [1:0]                       status
);

  localparam int CW = $clog2(MAX_WAITING + 1);

  // An admit always answers in the next cycle.
  `MRQS_ASSERT_NEXT(a_admit_latency, clk, rst, !rst && start && !busy && func == FUNC_ADMIT, done, "admit without result in next cycle")

  // With nothing running, all task fields read zero.
  `MRQS_ASSERT_NOW(a_idle_fields, clk, rst, done && !running_valid, running_id == '0 && quanta_left == '0 && quanta_elapsed == '0, "fields not zero without running task")

  // A switch only comes from a successful tick with a running task.
  `MRQS_ASSERT_NOW(a_switch_ok, clk, rst, done && switched, running_valid && status == STATUS_OK, "switch reported with bad status")

  // A full-queue drop is only reported when the queue is really full.
  `MRQS_ASSERT_NOW(a_full_count, clk, rst, done && status == STATUS_FULL, ready_count == CW'(MAX_WAITING) && running_valid, "queue full reported below capacity")

  // A tick without a task leaves nothing running.
  `MRQS_ASSERT_NOW(a_no_task, clk, rst, done && status == STATUS_NO_TASK, !running_valid && !switched, "no-task status with running task")

endmodule

bind max_remaining_quantum_scheduler_unit mrqs_checker #(
  .MAX_WAITING  (MAX_WAITING),
  .QUANTUM_BITS (QUANTUM_BITS),
  .ID_BITS      (ID_BITS)
) u_mrqs_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .func           (func),
  .done           (done),
  .running_valid  (running_valid),
  .running_id     (running_id),
  .quanta_left    (quanta_left),
  .quanta_elapsed (quanta_elapsed),
  .switched       (switched),
  .ready_count    (ready_count),
  .status         (status)
);

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mrqs_pkg::*;

  // Sizes match the defaults of the unit under test.
  localparam int MAX_WAITING  = 16;
  localparam int QUANTUM_BITS = 8;
  localparam int ID_BITS      = 8;
  localparam int COUNT_BITS   = $clog2(MAX_WAITING + 1);

  // A tick with tasks queued rotates the whole ring and then commits.
  localparam int TICK_LATENCY = MAX_WAITING + 2;

  localparam int ROW_COUNT    = 25;
  localparam int RANDOM_ITEMS = 800;
  // The last stretch of the random part runs with the sender never idle.
  localparam int CALM_ITEMS   = 100;
  localparam int REPORT_LIMIT = 10;

  // One scheduler result, laid out as the result ports.
  typedef struct {
    logic                    running_valid;
    logic [ID_BITS-1:0]      running_id;
    logic [QUANTUM_BITS-1:0] quanta_left;
    logic [QUANTUM_BITS-1:0] quanta_elapsed;
    logic                    switched;
    logic [COUNT_BITS-1:0]   ready_count;
    status_t                 status;
  } sched_result_t;

  // One command, with an optional hand-written result for the directed rows.
  typedef struct {
    logic                    func;
    logic [ID_BITS-1:0]      task_id;
    logic [QUANTUM_BITS-1:0] budget;
    bit                      typed;
    sched_result_t           result;
  } command_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    func = FUNC_ADMIT;
  logic [ID_BITS-1:0]      task_id = '0;
  logic [QUANTUM_BITS-1:0] quantum_budget = '0;
  logic                    busy;
  logic                    done;
  logic                    running_valid;
  logic [ID_BITS-1:0]      running_id;
  logic [QUANTUM_BITS-1:0] quanta_left;
  logic [QUANTUM_BITS-1:0] quanta_elapsed;
  logic                    switched;
  logic [COUNT_BITS-1:0]   ready_count;
  logic [1:0]              status;

  // The hand-written result travels with its command, so the monitor picks it
  // up at the same edge at which the command transfer happens.
  bit            row_typed = 1'b0;
  sched_result_t typed_result;

  max_remaining_quantum_scheduler_unit #(
    .MAX_WAITING  (MAX_WAITING),
    .QUANTUM_BITS (QUANTUM_BITS),
    .ID_BITS      (ID_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .task_id        (task_id),
    .quantum_budget (quantum_budget),
    .done           (done),
    .running_valid  (running_valid),
    .running_id     (running_id),
    .quanta_left    (quanta_left),
    .quanta_elapsed (quanta_elapsed),
    .switched       (switched),
    .ready_count    (ready_count),
    .status         (status)
  );

  always #2 clk = ~clk;

  // Shadow scheduler state. It starts in the reset state, and reset is only
  // applied once, so it needs no reset of its own.
  logic                    run_valid = 1'b0;
  logic [ID_BITS-1:0]      run_id = '0;
  logic [QUANTUM_BITS-1:0] run_left = '0;
  logic [QUANTUM_BITS-1:0] run_total = '0;
  logic [ID_BITS-1:0]      ready_ids    [MAX_WAITING];
  logic [QUANTUM_BITS-1:0] ready_left   [MAX_WAITING];
  logic [QUANTUM_BITS-1:0] ready_totals [MAX_WAITING];
  int                      ready_fill = 0;

  // Expected results in command order, and the number still owed by the
  // unit. The count is updated once per edge, so the sender reads it safely.
  sched_result_t awaited_results[$];
  int            outstanding = 0;
  int            error_count = 0;

  // Applies one command to the shadow state and returns the result it owes.
  function automatic sched_result_t advance_schedule(
      logic f, logic [ID_BITS-1:0] id, logic [QUANTUM_BITS-1:0] budget);
    sched_result_t           r;
    int                      pick;
    logic [ID_BITS-1:0]      pick_id;
    logic [QUANTUM_BITS-1:0] pick_left;
    logic [QUANTUM_BITS-1:0] pick_total;
    r.switched = 1'b0;
    r.status   = STATUS_OK;
    if (f == FUNC_ADMIT) begin
      if (!run_valid) begin
        run_valid = 1'b1;
        run_id    = id;
        run_left  = budget;
        run_total = budget;
      end else if (ready_fill >= MAX_WAITING) begin
        // A full queue drops the task and leaves everything else alone.
        r.status = STATUS_FULL;
      end else begin
        ready_ids[ready_fill]    = id;
        ready_left[ready_fill]   = budget;
        ready_totals[ready_fill] = budget;
        ready_fill++;
      end
    end else if (!run_valid) begin
      r.status = STATUS_NO_TASK;
    end else begin
      // An exhausted task gets its full quantum back before the choice.
      if (run_left == '0) run_left = run_total;
      if (ready_fill > 0) begin
        // Strictly greater keeps the earliest queued task on a tie.
        pick = 0;
        for (int i = 1; i < ready_fill; i++) begin
          if (ready_left[i] > ready_left[pick]) pick = i;
        end
        pick_id    = ready_ids[pick];
        pick_left  = ready_left[pick];
        pick_total = ready_totals[pick];
        for (int i = pick; i < ready_fill - 1; i++) begin
          ready_ids[i]    = ready_ids[i+1];
          ready_left[i]   = ready_left[i+1];
          ready_totals[i] = ready_totals[i+1];
        end
        ready_ids[ready_fill-1]    = run_id;
        ready_left[ready_fill-1]   = run_left;
        ready_totals[ready_fill-1] = run_total;
        run_id     = pick_id;
        run_left   = pick_left;
        run_total  = pick_total;
        r.switched = 1'b1;
      end
      // The count saturates at zero.
      if (run_left != '0) run_left--;
    end
    r.running_valid  = run_valid;
    r.running_id     = run_valid ? run_id : '0;
    r.quanta_left    = run_valid ? run_left : '0;
    r.quanta_elapsed = run_valid ? QUANTUM_BITS'(run_total - run_left) : '0;
    r.ready_count    = COUNT_BITS'(ready_fill);
    return r;
  endfunction

  // Result checking and command tracking. A result that shows up at the same
  // edge as a command transfer always belongs to an earlier command, so the
  // check runs before the new expectation is queued.
  always @(posedge clk) begin : result_monitor
    sched_result_t got;
    sched_result_t want;
    sched_result_t predicted;
    int            delta;
    delta = 0;
    if (!rst) begin
      if (done) begin
        got.running_valid  = running_valid;
        got.running_id     = running_id;
        got.quanta_left    = quanta_left;
        got.quanta_elapsed = quanta_elapsed;
        got.switched       = switched;
        got.ready_count    = ready_count;
        got.status         = status_t'(status);
        if (awaited_results.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("%0t: result with no command waiting: %s=%0d id=%0d status=%0d",
                     $realtime, "valid", running_valid, running_id, status);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          delta--;
          if (got.running_valid !== want.running_valid ||
              got.running_id !== want.running_id ||
              got.quanta_left !== want.quanta_left ||
              got.quanta_elapsed !== want.quanta_elapsed ||
              got.switched !== want.switched ||
              got.ready_count !== want.ready_count ||
              status !== want.status) begin
            if (error_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display({"  expected valid=%0d id=%0d left=%0d elapsed=%0d",
                        " switched=%0d ready=%0d status=%0d"},
                       want.running_valid, want.running_id, want.quanta_left,
                       want.quanta_elapsed, want.switched, want.ready_count, want.status);
              $display({"  actual   valid=%0d id=%0d left=%0d elapsed=%0d",
                        " switched=%0d ready=%0d status=%0d"},
                       running_valid, running_id, quanta_left, quanta_elapsed,
                       switched, ready_count, status);
            end
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        // The shadow state always advances; directed rows with a typed
        // result are held to that result instead of the prediction.
        predicted = advance_schedule(func, task_id, quantum_budget);
        awaited_results.push_back(row_typed ? typed_result : predicted);
        delta++;
      end
    end
    outstanding <= outstanding + delta;
  end

  function automatic command_row_t make_row(logic f, int id, int budget);
    command_row_t row;
    row.func    = f;
    row.task_id = ID_BITS'(id);
    row.budget  = QUANTUM_BITS'(budget);
    row.typed   = 1'b0;
    return row;
  endfunction

  // Presents a command and returns at the edge where the transfer happens.
  // Start stays high, so a following command goes out back to back.
  task automatic issue(input command_row_t row);
    start          <= 1'b1;
    func           <= row.func;
    task_id        <= row.task_id;
    quantum_budget <= row.budget;
    row_typed      <= row.typed;
    typed_result   <= row.result;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the next command back until every owed result has come out. The
  // first edge lets the count take in the transfer that just happened.
  task automatic settle_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    command_row_t rows[ROW_COUNT];
    command_row_t row;
    int           guard;

    // Directed rows: a tick with nothing to run, zero-quantum tasks that
    // exercise the refill to zero, saturation at zero and the choice among
    // an all-zero queue, a tie on the largest count, the queue filled to the
    // last slot, an admit to the full queue, and ticks over a full queue.
    rows = '{
      make_row(FUNC_TICK,    0,   0),
      make_row(FUNC_ADMIT,   0,   0),
      make_row(FUNC_TICK,    0,   0),
      make_row(FUNC_ADMIT,   1,   0),
      make_row(FUNC_ADMIT,   2,   0),
      make_row(FUNC_TICK,    0,   0),
      make_row(FUNC_ADMIT, 255, 255),
      make_row(FUNC_ADMIT,   3, 255),
      make_row(FUNC_TICK,  255, 255),
      make_row(FUNC_ADMIT,   4,   1),
      make_row(FUNC_ADMIT,   5,   2),
      make_row(FUNC_ADMIT,   6,   4),
      make_row(FUNC_ADMIT,   7,   8),
      make_row(FUNC_ADMIT,   8,  16),
      make_row(FUNC_ADMIT,   9,  32),
      make_row(FUNC_ADMIT,  10,  64),
      make_row(FUNC_ADMIT,  11, 128),
      make_row(FUNC_ADMIT,  12, 127),
      make_row(FUNC_ADMIT,  13, 170),
      make_row(FUNC_ADMIT,  14,  85),
      make_row(FUNC_ADMIT,  15, 200),
      make_row(FUNC_ADMIT, 170,  85),
      make_row(FUNC_TICK,  170,  85),
      make_row(FUNC_TICK,    0,   0),
      make_row(FUNC_TICK,  255, 255)
    };

    // Results that can be read straight off the spec: nothing runs after
    // reset; the first admit runs at once with its zero quantum; the tick on
    // a zero-quantum task refills it to zero and keeps it at zero.
    rows[0].typed  = 1'b1;
    rows[0].result = '{running_valid: 1'b0, running_id: '0, quanta_left: '0,
                       quanta_elapsed: '0, switched: 1'b0, ready_count: '0,
                       status: STATUS_NO_TASK};
    rows[1].typed  = 1'b1;
    rows[1].result = '{running_valid: 1'b1, running_id: '0, quanta_left: '0,
                       quanta_elapsed: '0, switched: 1'b0, ready_count: '0,
                       status: STATUS_OK};
    rows[2].typed  = 1'b1;
    rows[2].result = rows[1].result;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      issue(rows[i]);
      if ($urandom_range(0, 3) == 0) rest_sender($urandom_range(1, 10));
    end

    // Random commands. Ticks slightly outnumber admits; no command takes a task
    // off the queue, so it fills and then stays full. Short budgets are common
    // so that tasks run dry and get refilled.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row = make_row(($urandom_range(0, 99) < 55) ? FUNC_TICK : FUNC_ADMIT,
                     $urandom_range(0, 255),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(1, 255));
      issue(row);
      if (n == RANDOM_ITEMS / 3 ||
          (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) == 0))
        settle_results();
      else if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        rest_sender($urandom_range(1, 10));
    end

    start <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 50 * TICK_LATENCY) begin
      @(posedge clk);
      guard++;
    end
    // Any stray result after the last expected one is caught here.
    repeat (2 * TICK_LATENCY) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("max_remaining_quantum_scheduler_unit test passed");
    end else begin
      $display("max_remaining_quantum_scheduler_unit test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1ms;
    $display("max_remaining_quantum_scheduler_unit test failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/mrqs_pkg.sv
design/mrqs_cell.sv
design/max_remaining_quantum_scheduler_unit.sv
design/mrqs_checker.sv
tb/testbench.sv
